[design/csv_lfs_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csv_lfs_pkg
// Shared types and constants for the csv line field splitter.
// ----------------------------------------------------------------------------
package csv_lfs_pkg;

    localparam int MAX_FIELDS = 11;
    localparam int FIELD_W    = 4;
    localparam int OQ_DEPTH   = 4;
    localparam int OQ_PTR_W   = $clog2(OQ_DEPTH);
    localparam int OQ_CNT_W   = $clog2(OQ_DEPTH + 1);

    localparam logic [FIELD_W-1:0] FIELD_MAX = FIELD_W'(MAX_FIELDS);

    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_COMMA = 8'h2C;
    localparam logic [7:0] CH_NL    = 8'h0A;

    typedef enum logic {
        KIND_CHAR = 1'b0,
        KIND_END  = 1'b1
    } kind_t;

    typedef struct packed {
        kind_t              kind;
        logic [7:0]         out_byte;
        logic [FIELD_W-1:0] field_number;
        logic               field_empty;
        logic               line_done;
        logic               too_many_fields;
        logic               last;
    } res_t;

    // results of one beat, compacted into slot0 first
    typedef struct packed {
        logic [1:0] n;
        res_t       slot0;
        res_t       slot1;
    } push_t;

endpackage : csv_lfs_pkg
`default_nettype wire

[design/csv_lfs_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csv_lfs_core
// Line state and quote handling; turns one byte into up to two results.
// ----------------------------------------------------------------------------
module csv_lfs_core
    import csv_lfs_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,
    input  wire logic       advance,
    input  wire logic [7:0] in_byte,
    input  wire logic       line_end,
    output push_t           push
);

    logic               iq_reg, rqw_reg, lqw_reg, fhc_reg, ovf_reg;
    logic [FIELD_W-1:0] cf_reg;
    logic               iq_next, rqw_next, lqw_next, fhc_next, ovf_next;
    logic [FIELD_W-1:0] cf_next;

    always_comb begin
        logic               iq1, rqw1, lqw1, fhc1, ovf1, iq2;
        logic [FIELD_W-1:0] cf1;
        logic               do_lit, do_end, a_v, b_v;
        logic [7:0]         lit_x;
        res_t               ra, rb;

        iq1    = iq_reg;
        rqw1   = 1'b0;
        lqw1   = lqw_reg;
        cf1    = cf_reg;
        fhc1   = fhc_reg;
        ovf1   = ovf_reg;
        do_lit = 1'b0;
        do_end = 1'b0;
        lit_x  = in_byte;
        a_v    = 1'b0;
        b_v    = 1'b0;
        ra     = '0;
        rb     = '0;

        // raw stage: one quote of lookahead
        if (in_byte == CH_QUOTE) begin
            if (rqw_reg) begin
                do_lit = 1'b1;
            end else begin
                rqw1 = 1'b1;
            end
        end else begin
            if (rqw_reg) begin
                iq1 = !iq_reg;
            end
            if ((in_byte == CH_COMMA || in_byte == CH_NL) && !iq1) begin
                do_end = 1'b1;
            end else begin
                do_lit = 1'b1;
            end
        end

        ra.too_many_fields = ovf_reg;
        ra.field_number    = cf_reg;
        if (do_end) begin
            lqw1        = 1'b0;
            ra.kind     = KIND_END;
            ra.field_empty = !fhc_reg;
            if (cf_reg < FIELD_MAX) begin
                a_v = 1'b1;
                cf1 = cf_reg + FIELD_W'(1);
            end
            ovf1 = ovf_reg | (cf1 >= FIELD_MAX);
            fhc1 = 1'b0;
        end else if (do_lit) begin
            ra.kind     = KIND_CHAR;
            ra.out_byte = lit_x;
            if (cf_reg >= FIELD_MAX) begin
                lqw1 = 1'b0;
            end else if (lit_x == CH_QUOTE) begin
                // literal stage: a pair of quotes gives one
                if (lqw_reg) begin
                    lqw1 = 1'b0;
                    a_v  = 1'b1;
                    fhc1 = 1'b1;
                end else begin
                    lqw1 = 1'b1;
                end
            end else begin
                lqw1 = 1'b0;
                a_v  = 1'b1;
                fhc1 = 1'b1;
            end
        end

        iq2 = rqw1 ? !iq1 : iq1;
        rb.kind            = KIND_END;
        rb.line_done       = 1'b1;
        rb.too_many_fields = ovf1;
        if (cf1 < FIELD_MAX) begin
            rb.field_number = cf1;
            rb.field_empty  = !fhc1;
        end else begin
            rb.field_number = FIELD_MAX;
            rb.field_empty  = 1'b1;
        end
        b_v = line_end && !iq2;

        if (line_end) begin
            iq_next  = 1'b0;
            rqw_next = 1'b0;
            lqw_next = 1'b0;
            cf_next  = '0;
            fhc_next = 1'b0;
            ovf_next = 1'b0;
        end else begin
            iq_next  = iq1;
            rqw_next = rqw1;
            lqw_next = lqw1;
            cf_next  = cf1;
            fhc_next = fhc1;
            ovf_next = ovf1;
        end

        push.n     = {1'b0, a_v} + {1'b0, b_v};
        push.slot0 = a_v ? ra : rb;
        push.slot1 = rb;
        push.slot0.last = !(a_v && b_v);
        push.slot1.last = 1'b1;
        if (!advance) begin
            push.n = 2'd0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            iq_reg  <= 1'b0;
            rqw_reg <= 1'b0;
            lqw_reg <= 1'b0;
            cf_reg  <= '0;
            fhc_reg <= 1'b0;
            ovf_reg <= 1'b0;
        end else if (advance) begin
            iq_reg  <= iq_next;
            rqw_reg <= rqw_next;
            lqw_reg <= lqw_next;
            cf_reg  <= cf_next;
            fhc_reg <= fhc_next;
            ovf_reg <= ovf_next;
        end
    end

endmodule : csv_lfs_core
`default_nettype wire

[design/csv_lfs_outq.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csv_lfs_outq
// Small result queue: takes up to two results a cycle, sends one a beat.
// ----------------------------------------------------------------------------
module csv_lfs_outq
    import csv_lfs_pkg::*;
(
    input  wire logic aclk,
    input  wire logic aresetn,
    input  push_t     push,
    output logic      room,
    output logic      m_valid,
    input  wire logic m_ready,
    output res_t      m_res
);

    res_t                entry_reg [OQ_DEPTH];
    logic [OQ_PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [OQ_CNT_W-1:0] cnt_reg;
    logic [OQ_PTR_W-1:0] wr_ptr1;
    logic                pop;

    assign wr_ptr1 = wr_ptr_reg + OQ_PTR_W'(1);
    assign pop     = m_valid && m_ready;
    assign m_valid = cnt_reg != '0;
    assign m_res   = entry_reg[rd_ptr_reg];
    // room only while there is space for a full beat of two results
    assign room    = cnt_reg <= OQ_CNT_W'(OQ_DEPTH - 2);

    always_ff @(posedge aclk) begin
        if (push.n != 2'd0) begin
            entry_reg[wr_ptr_reg] <= push.slot0;
        end
        if (push.n == 2'd2) begin
            entry_reg[wr_ptr1] <= push.slot1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_reg + OQ_PTR_W'(push.n);
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + OQ_PTR_W'(1);
            end
            cnt_reg <= cnt_reg + OQ_CNT_W'(push.n) - OQ_CNT_W'(pop);
        end
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= OQ_CNT_W'(OQ_DEPTH))
        else $error("result queue count out of range");

    a_push_room: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n != 2'd0 |-> room)
        else $error("results pushed without room");

    a_pair_last: assert property (@(posedge aclk) disable iff (!aresetn)
        push.n == 2'd2 |-> push.slot1.last && !push.slot0.last
            && push.slot1.line_done)
        else $error("result pair badly marked");

    a_done_is_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_res.line_done |-> m_res.kind == KIND_END && m_res.last)
        else $error("line done on a non-final result");

endmodule : csv_lfs_outq
`default_nettype wire

[design/csv_line_field_splitter.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// csv_line_field_splitter
// Splits a CSV byte stream into field characters and field ends.
//
// Input channel s_axis: one character per beat in tdata, tlast marks the
// last byte of a line. Output channel m_axis: one result per beat, tuser
// is the kind (0 character, 1 field end), tlast marks the last result that
// an input byte caused. A byte gives zero, one or two results.
// Path: a byte accepted on s_axis is held in the input register, split by
// the core combinationally once the queue has room, and its results are
// written into the result queue, which drives m_axis.
// Throughput: one byte per cycle while each byte gives at most one result
// and the output queue has room; it drains one result per cycle while
// m_axis_tready is high, so bytes with two results can stall the input.
// A stalled receiver fills the four-entry result queue; s_axis_tready drops
// while the input register is full and fewer than two entries are free.
// Reset clears the line state and empties the queue and input register.
// ----------------------------------------------------------------------------
module csv_line_field_splitter
    import csv_lfs_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [7:0]  s_axis_tdata,   // [7:0] in_byte
    input  wire logic        s_axis_tlast,   // line_end
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,   // [7:0] out_byte, [11:8] field_number,
                                             // [12] field_empty, [13] line_done,
                                             // [14] too_many_fields, [15] zero
    output logic             m_axis_tuser,   // kind
    output logic             m_axis_tlast    // last
);

    logic       in_valid_reg;
    logic [7:0] in_byte_reg;
    logic       in_le_reg;
    logic       room, advance, s_accept;
    push_t      push;
    res_t       m_res;

    assign advance       = in_valid_reg && room;
    assign s_axis_tready = !in_valid_reg || room;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_accept) begin
            in_valid_reg <= 1'b1;
        end else if (advance) begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_byte_reg <= s_axis_tdata;
            in_le_reg   <= s_axis_tlast;
        end
    end

    csv_lfs_core u_core (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .advance  (advance),
        .in_byte  (in_byte_reg),
        .line_end (in_le_reg),
        .push     (push)
    );

    csv_lfs_outq u_outq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .push    (push),
        .room    (room),
        .m_valid (m_axis_tvalid),
        .m_ready (m_axis_tready),
        .m_res   (m_res)
    );

    assign m_axis_tdata = {1'b0, m_res.too_many_fields, m_res.line_done,
                           m_res.field_empty, m_res.field_number, m_res.out_byte};
    assign m_axis_tuser = m_res.kind;
    assign m_axis_tlast = m_res.last;

endmodule : csv_line_field_splitter
`default_nettype wire
